// ----- src/gmsc_pkg.sv -----
// Shared types and constants for the gate motion safety controller.
package gmsc_pkg;

  // Gate status codes reported on the result channel.
  typedef enum logic [2:0] {
    ST_CLOSED   = 3'd0,
    ST_OPENING  = 3'd1,
    ST_OPEN     = 3'd2,
    ST_CLOSING  = 3'd3,
    ST_STOPPED  = 3'd4,
    ST_REOPEN   = 3'd5
  } gate_status_t;

  // Operator command codes.
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HOLD_OPEN   = 3'd0;
  localparam logic [2:0] CFG_DEBOUNCE    = 3'd1;
  localparam logic [2:0] CFG_OPEN_STEP   = 3'd2;
  localparam logic [2:0] CFG_BUZZER      = 3'd3;
  localparam logic [2:0] CFG_SAFETY_STEP = 3'd4;
  localparam logic [2:0] CFG_OBSTRUCTION = 3'd5;

  // Configuration reset values.
  localparam logic [15:0] RST_HOLD_OPEN   = 16'd5000;
  localparam logic [9:0]  RST_DEBOUNCE    = 10'd200;
  localparam logic [7:0]  RST_OPEN_STEP   = 8'd20;
  localparam logic [15:0] RST_BUZZER      = 16'd1000;
  localparam logic [7:0]  RST_SAFETY_STEP = 8'd20;
  localparam logic [8:0]  RST_OBSTRUCTION = 9'd20;

  // Closing step delay is CLOSE_BASE_MS - floor(pot * 50 / POT_FULL).
  localparam logic [5:0]  CLOSE_BASE_MS = 6'd60;
  localparam logic [12:0] POT_FULL      = 13'd4095;

endpackage

// ----- src/gate_motion_safety_controller.sv -----
// Top level of the gate motion safety controller: one millisecond tick per beat.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall  | pir_motion, button_level, pot_level,
//          |           |                      | distance_cm, cmd
//  out_    | output    | out_valid / out_stall| servo_angle, buzzer_on, red_lamp,
//          |           |                      | gate_status, manual_active
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index (3), cfg_data (16)
//
// One tick beat is accepted every cycle while the input channel is not stalled; a beat
// taken into the input register has its result loaded into the result register when it moves on.
// The whole tick update is a single combinational pass from the input register.
// Reset is synchronous on rst_n low; it loads the gate state and register defaults.
// A stalled result holds the result register, which then stalls the input register
// and the input channel; the configuration port never stalls.
module gate_motion_safety_controller
  import gmsc_pkg::*;
#(
  parameter int OPEN_ANGLE = 90
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_pir_motion,
  input  logic        in_button_level,
  input  logic [11:0] in_pot_level,
  input  logic [8:0]  in_distance_cm,
  input  logic [1:0]  in_cmd,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_servo_angle,
  output logic        out_buzzer_on,
  output logic        out_red_lamp,
  output logic [2:0]  out_gate_status,
  output logic        out_manual_active,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Angle register is wide enough for OPEN_ANGLE and for the 7-bit output.
  localparam int AngBits = $clog2(OPEN_ANGLE + 1);
  localparam int AW      = (AngBits > 7) ? AngBits : 7;
  localparam logic [AW-1:0] OpenAng = AW'(OPEN_ANGLE);

  // Configuration registers.
  logic [15:0] hold_open_r;
  logic [9:0]  debounce_r;
  logic [7:0]  open_step_r;
  logic [15:0] buzzer_ms_r;
  logic [7:0]  safety_step_r;
  logic [8:0]  obstruction_r;

  // Input register stage.
  logic        s1_valid_r;
  logic        pir_r;
  logic        button_r;
  logic [11:0] pot_r;
  logic [8:0]  dist_r;
  logic [1:0]  cmd_r;
  logic        s1_adv;

  // Gate state.
  logic [31:0] now_r, now_nxt;
  logic [31:0] last_press_r, last_press_nxt;
  logic [31:0] idle_since_r, idle_since_nxt;
  logic [31:0] open_move_r, open_move_nxt;
  logic [31:0] close_move_r, close_move_nxt;
  logic [31:0] alarm_start_r, alarm_start_nxt;
  logic [31:0] reopen_move_r, reopen_move_nxt;
  logic [AW-1:0] angle_r, angle_nxt;
  logic        manual_r, manual_nxt;
  logic        prev_button_r, prev_button_nxt;
  logic        is_open_r, is_open_nxt;
  logic        opening_r, opening_nxt;
  logic        closing_r, closing_nxt;
  logic        safety_r, safety_nxt;
  logic        reopen_r, reopen_nxt;
  logic        lamp_r, lamp_nxt;
  logic        buzzer_r, buzzer_nxt;
  gate_status_t status_nxt;

  // Result register.
  logic          out_valid_r;
  logic [6:0]    servo_angle_r;
  logic          buzzer_on_r;
  logic          red_lamp_r;
  gate_status_t  gate_status_r;
  logic          manual_active_r;

  // Closing step delay from the potentiometer.
  logic [17:0] pot_x50;
  logic [5:0]  quo_est;
  logic [12:0] quo_rem;
  logic [5:0]  quo;
  logic [5:0]  close_delay;

  logic        obstructed;
  logic        path_clear;

  // Handshakes: the input register moves on when the result register is free.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign cfg_ready = 1'b1;

  // floor(pot*50/4095): estimate with a shift, then one correction step.
  always_comb begin
    pot_x50     = {1'b0, pot_r, 5'b0} + {2'b0, pot_r, 4'b0} + {5'b0, pot_r, 1'b0};
    quo_est     = pot_x50[17:12];
    quo_rem     = {1'b0, pot_x50[11:0]} + {7'b0, quo_est};
    quo         = (quo_rem >= POT_FULL) ? quo_est + 6'd1 : quo_est;
    close_delay = CLOSE_BASE_MS - quo;
  end

  assign obstructed = (dist_r != 9'd0) && (dist_r < obstruction_r);
  assign path_clear = (dist_r >= obstruction_r);

  // Tick update, in the order button, opening, closing, buzzer, reopening,
  // automatic control, manual command.
  always_comb begin
    now_nxt         = now_r + 32'd1;
    last_press_nxt  = last_press_r;
    idle_since_nxt  = idle_since_r;
    open_move_nxt   = open_move_r;
    close_move_nxt  = close_move_r;
    alarm_start_nxt = alarm_start_r;
    reopen_move_nxt = reopen_move_r;
    angle_nxt       = angle_r;
    manual_nxt      = manual_r;
    is_open_nxt     = is_open_r;
    opening_nxt     = opening_r;
    closing_nxt     = closing_r;
    safety_nxt      = safety_r;
    reopen_nxt      = reopen_r;
    lamp_nxt        = lamp_r;
    buzzer_nxt      = buzzer_r;

    // Mode button: a debounced falling edge toggles the mode.
    if (!button_r && prev_button_r &&
        ((now_nxt - last_press_r) >= {22'b0, debounce_r})) begin
      last_press_nxt = now_nxt;
      manual_nxt     = !manual_r;
      idle_since_nxt = 32'd0;
      if (!manual_r) begin
        lamp_nxt = 1'b0;
      end
    end
    prev_button_nxt = button_r;

    // Opening steps one degree per open step time.
    if (opening_nxt && ((now_nxt - open_move_nxt) >= {24'b0, open_step_r})) begin
      open_move_nxt = now_nxt;
      if (angle_nxt < OpenAng) begin
        angle_nxt = angle_nxt + AW'(1);
      end else begin
        opening_nxt = 1'b0;
        is_open_nxt = 1'b1;
      end
    end

    // Closing steps down, or stops on an obstruction.
    if (closing_nxt && ((now_nxt - close_move_nxt) >= {26'b0, close_delay})) begin
      close_move_nxt = now_nxt;
      if (obstructed) begin
        closing_nxt     = 1'b0;
        safety_nxt      = 1'b1;
        buzzer_nxt      = 1'b1;
        alarm_start_nxt = now_nxt;
      end else if (angle_nxt != '0) begin
        angle_nxt = angle_nxt - AW'(1);
      end else begin
        closing_nxt = 1'b0;
        is_open_nxt = 1'b0;
        angle_nxt   = '0;
      end
    end

    // Buzzer timeout starts the safety reopening.
    if (safety_nxt && !reopen_nxt &&
        ((now_nxt - alarm_start_nxt) >= {16'b0, buzzer_ms_r})) begin
      buzzer_nxt      = 1'b0;
      reopen_nxt      = 1'b1;
      reopen_move_nxt = now_nxt;
    end

    // Safety reopening steps up until fully open.
    if (reopen_nxt && ((now_nxt - reopen_move_nxt) >= {24'b0, safety_step_r})) begin
      reopen_move_nxt = now_nxt;
      if (angle_nxt < OpenAng) begin
        angle_nxt = angle_nxt + AW'(1);
      end else begin
        reopen_nxt     = 1'b0;
        safety_nxt     = 1'b0;
        is_open_nxt    = 1'b1;
        angle_nxt      = OpenAng;
        idle_since_nxt = 32'd0;
      end
    end

    // Automatic control: motion opens, a hold timer closes on a clear path.
    if (!manual_nxt && !safety_nxt) begin
      if (pir_r) begin
        lamp_nxt       = 1'b1;
        idle_since_nxt = 32'd0;
        if (!is_open_nxt && !opening_nxt) begin
          opening_nxt   = 1'b1;
          open_move_nxt = now_nxt;
        end
      end else begin
        lamp_nxt = 1'b0;
        if (is_open_nxt && !closing_nxt) begin
          if (idle_since_nxt == 32'd0) begin
            idle_since_nxt = now_nxt;
          end
          if ((now_nxt - idle_since_nxt) >= {16'b0, hold_open_r}) begin
            if (path_clear) begin
              idle_since_nxt = 32'd0;
              closing_nxt    = 1'b1;
              angle_nxt      = OpenAng;
              close_move_nxt = now_nxt;
            end else begin
              idle_since_nxt = now_nxt;
            end
          end
        end
      end
    end

    // Manual command.
    if (manual_nxt) begin
      if (cmd_r == CMD_OPEN) begin
        if (!is_open_nxt && !opening_nxt) begin
          opening_nxt   = 1'b1;
          open_move_nxt = now_nxt;
        end
      end else if (cmd_r == CMD_CLOSE) begin
        if (is_open_nxt && !closing_nxt) begin
          closing_nxt    = 1'b1;
          angle_nxt      = OpenAng;
          close_move_nxt = now_nxt;
        end
      end
    end

    // Reported status, safety first.
    if (reopen_nxt) begin
      status_nxt = ST_REOPEN;
    end else if (safety_nxt) begin
      status_nxt = ST_STOPPED;
    end else if (opening_nxt) begin
      status_nxt = ST_OPENING;
    end else if (closing_nxt) begin
      status_nxt = ST_CLOSING;
    end else if (is_open_nxt) begin
      status_nxt = ST_OPEN;
    end else begin
      status_nxt = ST_CLOSED;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_open_r   <= RST_HOLD_OPEN;
      debounce_r    <= RST_DEBOUNCE;
      open_step_r   <= RST_OPEN_STEP;
      buzzer_ms_r   <= RST_BUZZER;
      safety_step_r <= RST_SAFETY_STEP;
      obstruction_r <= RST_OBSTRUCTION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLD_OPEN:   hold_open_r   <= cfg_data;
        CFG_DEBOUNCE:    debounce_r    <= cfg_data[9:0];
        CFG_OPEN_STEP:   open_step_r   <= cfg_data[7:0];
        CFG_BUZZER:      buzzer_ms_r   <= cfg_data;
        CFG_SAFETY_STEP: safety_step_r <= cfg_data[7:0];
        CFG_OBSTRUCTION: obstruction_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Input register: takes a beat whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pir_r    <= in_pir_motion;
      button_r <= in_button_level;
      pot_r    <= in_pot_level;
      dist_r   <= in_distance_cm;
      cmd_r    <= in_cmd;
    end
  end

  // Gate state advances once per tick that enters the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= 32'd0;
      last_press_r  <= 32'd0;
      idle_since_r  <= 32'd0;
      open_move_r   <= 32'd0;
      close_move_r  <= 32'd0;
      alarm_start_r <= 32'd0;
      reopen_move_r <= 32'd0;
      angle_r       <= '0;
      manual_r      <= 1'b0;
      prev_button_r <= 1'b1;
      is_open_r     <= 1'b0;
      opening_r     <= 1'b0;
      closing_r     <= 1'b0;
      safety_r      <= 1'b0;
      reopen_r      <= 1'b0;
      lamp_r        <= 1'b0;
      buzzer_r      <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      now_r         <= now_nxt;
      last_press_r  <= last_press_nxt;
      idle_since_r  <= idle_since_nxt;
      open_move_r   <= open_move_nxt;
      close_move_r  <= close_move_nxt;
      alarm_start_r <= alarm_start_nxt;
      reopen_move_r <= reopen_move_nxt;
      angle_r       <= angle_nxt;
      manual_r      <= manual_nxt;
      prev_button_r <= prev_button_nxt;
      is_open_r     <= is_open_nxt;
      opening_r     <= opening_nxt;
      closing_r     <= closing_nxt;
      safety_r      <= safety_nxt;
      reopen_r      <= reopen_nxt;
      lamp_r        <= lamp_nxt;
      buzzer_r      <= buzzer_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      servo_angle_r   <= angle_nxt[6:0];
      buzzer_on_r     <= buzzer_nxt;
      red_lamp_r      <= lamp_nxt;
      gate_status_r   <= status_nxt;
      manual_active_r <= manual_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_angle   = servo_angle_r;
  assign out_buzzer_on     = buzzer_on_r;
  assign out_red_lamp      = red_lamp_r;
  assign out_gate_status   = gate_status_r;
  assign out_manual_active = manual_active_r;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the gate motion safety controller, with its own tick predictor.
`timescale 1ns / 100ps

module tb_top
  import gmsc_pkg::*;
();

  localparam int GATE_OPEN_ANGLE = 90;
  localparam int MAX_CYCLES = 200000;
  localparam int unsigned CLOSE_SPAN = 50;
  localparam int MAX_REPORTS = 10;

  // Command codes that the package leaves unnamed.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Register index outside the register map.
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic        pir;
    logic        button;
    logic [11:0] pot;
    logic [8:0]  distance;
    logic [1:0]  cmd;
  } tick_t;

  typedef struct packed {
    logic [6:0]   angle;
    logic         buzzer;
    logic         lamp;
    gate_status_t status;
    logic         manual;
  } gate_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tick_t       drv_tick = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_servo_angle;
  logic        out_buzzer_on;
  logic        out_red_lamp;
  logic [2:0]  out_gate_status;
  logic        out_manual_active;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tick_t      tick_queue[$];
  gate_view_t views_due[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         in_idle_pct = 0;
  int         out_stall_pct = 0;

  // Register copies used by the predictor.
  int unsigned reg_hold = RST_HOLD_OPEN;
  int unsigned reg_debounce = RST_DEBOUNCE;
  int unsigned reg_open_step = RST_OPEN_STEP;
  int unsigned reg_buzzer = RST_BUZZER;
  int unsigned reg_safety_step = RST_SAFETY_STEP;
  int unsigned reg_obstruction = RST_OBSTRUCTION;

  // Predicted gate state, starting from its reset values.
  int unsigned clock_ms = 0;
  int unsigned press_ms = 0;
  int unsigned hold_start_ms = 0;
  int unsigned open_step_at = 0;
  int unsigned close_step_at = 0;
  int unsigned alarm_at = 0;
  int unsigned reopen_step_at = 0;
  int unsigned gate_angle = 0;
  bit mode_manual = 1'b0;
  bit btn_prev = 1'b1;
  bit gate_open = 1'b0;
  bit gate_opening = 1'b0;
  bit gate_closing = 1'b0;
  bit alarm_active = 1'b0;
  bit reopening = 1'b0;
  bit lamp_on = 1'b0;
  bit buzz_on = 1'b0;

  gate_motion_safety_controller #(
    .OPEN_ANGLE(GATE_OPEN_ANGLE)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pir_motion(drv_tick.pir),
    .in_button_level(drv_tick.button),
    .in_pot_level(drv_tick.pot),
    .in_distance_cm(drv_tick.distance),
    .in_cmd(drv_tick.cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_servo_angle(out_servo_angle),
    .out_buzzer_on(out_buzzer_on),
    .out_red_lamp(out_red_lamp),
    .out_gate_status(out_gate_status),
    .out_manual_active(out_manual_active),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Advance the predicted gate by one millisecond tick and report its outputs.
  task automatic step_gate(input tick_t t, output gate_view_t v);
    int unsigned pot_u;
    int unsigned dist_u;
    int unsigned close_delay;
    pot_u = t.pot;
    dist_u = t.distance;
    clock_ms = clock_ms + 1;

    // Mode button: falling edge outside the debounce window toggles the mode.
    if (!t.button && btn_prev && (clock_ms - press_ms) >= reg_debounce) begin
      press_ms = clock_ms;
      mode_manual = !mode_manual;
      hold_start_ms = 0;
      if (mode_manual) lamp_on = 1'b0;
    end
    btn_prev = t.button;

    // Opening moves one degree per open step; one extra step marks the gate open.
    if (gate_opening && (clock_ms - open_step_at) >= reg_open_step) begin
      open_step_at = clock_ms;
      if (gate_angle < GATE_OPEN_ANGLE) begin
        gate_angle++;
      end else begin
        gate_opening = 1'b0;
        gate_open = 1'b1;
      end
    end

    // Closing speed follows the potentiometer; an obstruction stops the gate.
    if (gate_closing) begin
      close_delay = CLOSE_BASE_MS - (pot_u * CLOSE_SPAN) / POT_FULL;
      if ((clock_ms - close_step_at) >= close_delay) begin
        close_step_at = clock_ms;
        if (dist_u > 0 && dist_u < reg_obstruction) begin
          gate_closing = 1'b0;
          alarm_active = 1'b1;
          buzz_on = 1'b1;
          alarm_at = clock_ms;
        end else if (gate_angle > 0) begin
          gate_angle--;
        end else begin
          gate_closing = 1'b0;
          gate_open = 1'b0;
          gate_angle = 0;
        end
      end
    end

    // The buzzer sounds for its set time, then the safety reopening starts.
    if (alarm_active && !reopening && (clock_ms - alarm_at) >= reg_buzzer) begin
      buzz_on = 1'b0;
      reopening = 1'b1;
      reopen_step_at = clock_ms;
    end

    if (reopening && (clock_ms - reopen_step_at) >= reg_safety_step) begin
      reopen_step_at = clock_ms;
      if (gate_angle < GATE_OPEN_ANGLE) begin
        gate_angle++;
      end else begin
        reopening = 1'b0;
        alarm_active = 1'b0;
        gate_open = 1'b1;
        gate_angle = GATE_OPEN_ANGLE;
        hold_start_ms = 0;
      end
    end

    // Automatic mode: motion opens the gate, a clear path after the hold time closes it.
    if (!mode_manual && !alarm_active) begin
      if (t.pir) begin
        lamp_on = 1'b1;
        hold_start_ms = 0;
        if (!gate_open && !gate_opening) begin
          gate_opening = 1'b1;
          open_step_at = clock_ms;
        end
      end else begin
        lamp_on = 1'b0;
        if (gate_open && !gate_closing) begin
          if (hold_start_ms == 0) hold_start_ms = clock_ms;
          if ((clock_ms - hold_start_ms) >= reg_hold) begin
            if (dist_u >= reg_obstruction) begin
              hold_start_ms = 0;
              gate_closing = 1'b1;
              gate_angle = GATE_OPEN_ANGLE;
              close_step_at = clock_ms;
            end else begin
              hold_start_ms = clock_ms;
            end
          end
        end
      end
    end

    // Manual mode: operator commands.
    if (mode_manual) begin
      if (t.cmd == CMD_OPEN) begin
        if (!gate_open && !gate_opening) begin
          gate_opening = 1'b1;
          open_step_at = clock_ms;
        end
      end else if (t.cmd == CMD_CLOSE) begin
        if (gate_open && !gate_closing) begin
          gate_closing = 1'b1;
          gate_angle = GATE_OPEN_ANGLE;
          close_step_at = clock_ms;
        end
      end
    end

    if (reopening) v.status = ST_REOPEN;
    else if (alarm_active) v.status = ST_STOPPED;
    else if (gate_opening) v.status = ST_OPENING;
    else if (gate_closing) v.status = ST_CLOSING;
    else if (gate_open) v.status = ST_OPEN;
    else v.status = ST_CLOSED;
    v.angle = gate_angle[6:0];
    v.buzzer = buzz_on;
    v.lamp = lamp_on;
    v.manual = mode_manual;
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Tick driver: predicts each accepted beat, then offers the next pending tick.
  always @(posedge clk) begin : drive_ticks
    gate_view_t view;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_gate(drv_tick, view);
        views_due.push_back(view);
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          drv_tick <= tick_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted beat with the oldest prediction.
  always @(posedge clk) begin : check_views
    gate_view_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (views_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing predicted (angle %0d status %0d)",
                     $time, out_servo_angle, out_gate_status);
        end else begin
          want = views_due.pop_front();
          if (out_servo_angle !== want.angle || out_buzzer_on !== want.buzzer ||
              out_red_lamp !== want.lamp || out_gate_status !== want.status ||
              out_manual_active !== want.manual) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"%0t: mismatch, expected angle %0d buzzer %0b lamp %0b status %0d ",
                        "manual %0b, got angle %0d buzzer %0b lamp %0b status %0d manual %0b"},
                       $time, want.angle, want.buzzer, want.lamp, want.status, want.manual,
                       out_servo_angle, out_buzzer_on, out_red_lamp, out_gate_status,
                       out_manual_active);
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // One register write; the predictor takes the value at the handshake.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HOLD_OPEN: reg_hold = data;
      CFG_DEBOUNCE: reg_debounce = data[9:0];
      CFG_OPEN_STEP: reg_open_step = data[7:0];
      CFG_BUZZER: reg_buzzer = data;
      CFG_SAFETY_STEP: reg_safety_step = data[7:0];
      CFG_OBSTRUCTION: reg_obstruction = data[8:0];
      default: ;
    endcase
  endtask

  // Writes every register, with random bits above each narrower register's width, and sometimes the spare index.
  task automatic load_settings(input logic [15:0] hold_ms, input logic [9:0] debounce,
                               input logic [7:0] open_step, input logic [15:0] buzz_ms,
                               input logic [7:0] safety_step, input logic [8:0] obstruction);
    write_reg(CFG_HOLD_OPEN, hold_ms);
    write_reg(CFG_DEBOUNCE, {6'($urandom), debounce});
    write_reg(CFG_OPEN_STEP, {8'($urandom), open_step});
    write_reg(CFG_BUZZER, buzz_ms);
    write_reg(CFG_SAFETY_STEP, {8'($urandom), safety_step});
    write_reg(CFG_OBSTRUCTION, {7'($urandom), obstruction});
    if ($urandom_range(1) != 0) write_reg(CFG_SPARE, 16'($urandom));
  endtask

  // Waits until every tick is accepted and every predicted result has arrived.
  task automatic settle();
    do @(negedge clk); while (tick_queue.size() != 0 || in_valid || views_due.size() != 0);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    in_idle_pct = (mode == IDLE_SENDER) ? 45 : (mode == IDLE_BOTH) ? 34 : 0;
    out_stall_pct = (mode == IDLE_RECEIVER) ? 45 : (mode == IDLE_BOTH) ? 34 : 0;
  endtask

  task automatic add_tick(input logic pir, input logic button, input logic [11:0] pot,
                          input logic [8:0] distance, input logic [1:0] cmd);
    tick_t t;
    t.pir = pir;
    t.button = button;
    t.pot = pot;
    t.distance = distance;
    t.cmd = cmd;
    tick_queue.push_back(t);
  endtask

  // Distances grouped around the obstruction threshold.
  function automatic logic [8:0] pick_distance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 9'd0;
    if (r < 35 && reg_obstruction > 1) return 9'($urandom_range(1, reg_obstruction - 1));
    if (r < 45) return reg_obstruction[8:0];
    if (r < 50) return 9'd511;
    return 9'($urandom_range(reg_obstruction, 511));
  endfunction

  // Realistic traffic: motion in bursts, held distances, short button presses,
  // occasional commands, and a small share of fully random ticks.
  task automatic queue_traffic(input int count);
    tick_t t;
    bit pir_lvl;
    int pir_run;
    int dist_run;
    int press_left;
    logic [8:0] dist_lvl;
    int unsigned r;
    pir_lvl = 1'b0;
    pir_run = 0;
    dist_run = 0;
    press_left = 0;
    dist_lvl = '0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 6) begin
        t.pir = 1'($urandom);
        t.button = ($urandom_range(3) != 0);
        t.pot = 12'($urandom);
        t.distance = 9'($urandom);
        t.cmd = 2'($urandom);
      end else begin
        if (pir_run == 0) begin
          pir_lvl = !pir_lvl;
          pir_run = pir_lvl ? $urandom_range(1, 60) : $urandom_range(20, 400);
        end
        pir_run--;
        if (dist_run == 0) begin
          dist_lvl = pick_distance();
          dist_run = $urandom_range(1, 80);
        end
        dist_run--;
        if (press_left == 0 && $urandom_range(999) < 6) press_left = $urandom_range(1, 15);
        t.button = (press_left == 0);
        if (press_left > 0) press_left--;
        t.pir = pir_lvl;
        t.distance = dist_lvl;
        t.pot = ($urandom_range(99) < 75) ? 12'($urandom_range(3600, 4095)) :
                                             12'($urandom_range(0, 4095));
        r = $urandom_range(99);
        if (r < 85) t.cmd = CMD_NONE;
        else if (r < 92) t.cmd = CMD_OPEN;
        else if (r < 98) t.cmd = CMD_CLOSE;
        else t.cmd = CMD_UNUSED;
      end
      tick_queue.push_back(t);
    end
  endtask

  task automatic run_phase(input idle_mode_t mode, input int count);
    @(negedge clk);
    set_idling(mode);
    queue_traffic(count);
    settle();
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks with zero open and safety step times so that opening and reopening move every tick.
    load_settings(16'd2, 10'd3, 8'd0, 16'd1, 8'd0, 9'd20);
    @(negedge clk);
    set_idling(IDLE_NONE);
    add_tick(1'b0, 1'b1, 12'd0, 9'd0, CMD_NONE);
    add_tick(1'b1, 1'b1, 12'd4095, 9'd511, CMD_UNUSED);
    add_tick(1'b1, 1'b1, 12'd0, 9'd0, CMD_OPEN);
    add_tick(1'b0, 1'b1, 12'd2047, 9'd19, CMD_CLOSE);
    add_tick(1'b0, 1'b0, 12'd4095, 9'd20, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd4095, 9'd21, CMD_UNUSED);
    add_tick(1'b0, 1'b1, 12'd0, 9'd1, CMD_CLOSE);
    add_tick(1'b0, 1'b0, 12'd0, 9'd0, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd100, 9'd511, CMD_NONE);
    add_tick(1'b0, 1'b0, 12'd100, 9'd511, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd2730, 9'd255, CMD_NONE);
    add_tick(1'b1, 1'b0, 12'd1365, 9'd256, CMD_OPEN);
    add_tick(1'b1, 1'b1, 12'd4095, 9'd200, CMD_OPEN);
    add_tick(1'b0, 1'b1, 12'd0, 9'd511, CMD_CLOSE);
    add_tick(1'b1, 1'b1, 12'd4094, 9'd0, CMD_UNUSED);
    add_tick(1'b0, 1'b1, 12'd1, 9'd1, CMD_NONE);
    add_tick(1'b0, 1'b0, 12'd4095, 9'd19, CMD_NONE);
    add_tick(1'b1, 1'b1, 12'd0, 9'd20, CMD_NONE);
    add_tick(1'b1, 1'b1, 12'd4095, 9'd511, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd4095, 9'd511, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd4095, 9'd0, CMD_NONE);
    add_tick(1'b0, 1'b1, 12'd2048, 9'd10, CMD_NONE);
    settle();

    // Random traffic under a range of settings, the extremes among them.
    load_settings(16'd5, 10'd10, 8'd1, 16'd3, 8'd1, 9'd20);
    run_phase(IDLE_NONE, 400);
    load_settings(16'd0, 10'd0, 8'd0, 16'd0, 8'd0, 9'd1);
    run_phase(IDLE_SENDER, 400);
    load_settings(16'd20, 10'd1023, 8'd2, 16'd10, 8'd3, 9'd511);
    run_phase(IDLE_RECEIVER, 300);
    load_settings(16'd1, 10'd5, 8'd1, 16'd5, 8'd2, 9'd0);
    run_phase(IDLE_BOTH, 300);
    load_settings(16'd65535, 10'd1023, 8'd255, 16'd65535, 8'd255, 9'd300);
    run_phase(IDLE_NONE, 150);
    load_settings(RST_HOLD_OPEN, RST_DEBOUNCE, RST_OPEN_STEP, RST_BUZZER, RST_SAFETY_STEP,
                  RST_OBSTRUCTION);
    run_phase(IDLE_SENDER, 250);

    // Leave room for any stray late beat before the verdict.
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
